>>> rtl/bfia_pkg.sv
// shared types and constants for the bidirectional flow id assigner
// used by bfia_ctrl, bfia_datapath and the core top level
package bfia_pkg;

   localparam int ADDR_W   = 64;
   localparam int PORT_W   = 16;
   localparam int NUM_W    = 8;
   localparam int KEY_W    = 4 * ADDR_W + 2 * PORT_W;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic load;
      logic rd_start;
      logic rd_next;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic ip;
      logic scan_done;
      logic hit;
      logic full;
   } sts_type;

endpackage

>>> rtl/bfia_datapath.sv
// datapath: canonical key ordering, flow memory, scan index and count
// depends on bfia_pkg
module bfia_datapath #(
   parameter int FLOW_ENTRIES = 256,
   parameter int IDX_W        = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bfia_pkg::cmd_type       cmd,
   output bfia_pkg::sts_type       sts,
   input  logic                    req_ip_present,
   input  logic [63:0]             req_src_addr_hi,
   input  logic [63:0]             req_src_addr_lo,
   input  logic [63:0]             req_dst_addr_hi,
   input  logic [63:0]             req_dst_addr_lo,
   input  logic [15:0]             req_src_port,
   input  logic [15:0]             req_dst_port,
   output logic [7:0]              number
);
   import bfia_pkg::*;

   key_type              mem [FLOW_ENTRIES];
   key_type              key_ff, rd_ff;
   logic                 ip_ff;
   logic [IDX_W:0]       count_ff, count_in;
   logic [IDX_W:0]       idx_ff, idx_in;
   logic [IDX_W:0]       cmp_ff;
   logic                 rd_vld_ff;
   logic                 hit_ff;
   logic [IDX_W:0]       hit_idx_ff;
   logic                 less;
   key_type              key_in;

   always_comb begin
      priority if (req_src_addr_hi != req_dst_addr_hi) begin
         less = req_src_addr_hi < req_dst_addr_hi;
      end else if (req_src_addr_lo != req_dst_addr_lo) begin
         less = req_src_addr_lo < req_dst_addr_lo;
      end else begin
         less = req_src_port < req_dst_port;
      end
      if (less) begin
         key_in = {req_src_addr_hi, req_src_addr_lo, req_dst_addr_hi, req_dst_addr_lo,
                   req_src_port, req_dst_port};
      end else begin
         key_in = {req_dst_addr_hi, req_dst_addr_lo, req_src_addr_hi, req_src_addr_lo,
                   req_dst_port, req_src_port};
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.rd_start) begin
         idx_in = '0;
      end else if (cmd.rd_next && idx_ff < count_ff) begin
         idx_in = idx_ff + 1'b1;
      end
      count_in = count_ff;
      if (cmd.write) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key_in;
         ip_ff  <= req_ip_present;
      end
      if (cmd.write) begin
         mem[count_ff[IDX_W-1:0]] <= key_ff;
      end
      rd_ff  <= mem[idx_ff[IDX_W-1:0]];
      cmp_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         hit_idx_ff <= '0;
      end else begin
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= (cmd.rd_start || cmd.rd_next) && idx_in < count_ff && !cmd.rd_start
                      ? 1'b1 : (cmd.rd_next && idx_ff < count_ff);
         if (cmd.rd_start) begin
            hit_ff <= 1'b0;
         end else if (rd_vld_ff && !hit_ff && rd_ff == key_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= cmp_ff;
         end
      end
   end

   assign sts.ip        = ip_ff;
   assign sts.hit       = hit_ff;
   assign sts.scan_done = !rd_vld_ff && idx_ff >= count_ff && !cmd.rd_start;
   assign sts.full      = count_ff >= (IDX_W+1)'(FLOW_ENTRIES);
   assign number        = hit_ff ? NUM_W'(hit_idx_ff) : NUM_W'(count_ff);

endmodule

>>> rtl/bfia_ctrl.sv
// controller: sequences load, memory scan, insert and response
// depends on bfia_pkg
module bfia_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bfia_pkg::cmd_type  cmd,
   input  bfia_pkg::sts_type  sts,
   input  logic [7:0]         number,
   output logic               rsp_stream_valid,
   output logic [7:0]         rsp_stream_number,
   output logic               rsp_new_stream,
   output logic               rsp_table_full
);
   import bfia_pkg::*;

   typedef enum logic [1:0] {IDLE, START, SCAN, RESP} state_type;
   state_type state_ff;

   assign req_stall = state_ff != IDLE;

   always_comb begin
      cmd = '0;
      cmd.load     = state_ff == IDLE && req_valid;
      cmd.rd_start = state_ff == START;
      cmd.rd_next  = state_ff == SCAN;
      cmd.write    = state_ff == SCAN && sts.ip && sts.scan_done && !sts.hit && !sts.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: if (req_valid) state_ff <= START;
            START: state_ff <= SCAN;
            SCAN: begin
               if (!sts.ip) begin
                  rsp_stream_valid  <= 1'b0;
                  rsp_stream_number <= '0;
                  rsp_new_stream    <= 1'b0;
                  rsp_table_full    <= 1'b0;
                  rsp_valid         <= 1'b1;
                  state_ff          <= RESP;
               end else if (sts.scan_done || sts.hit) begin
                  rsp_stream_valid  <= sts.hit || !sts.full;
                  rsp_stream_number <= (sts.hit || !sts.full) ? number : '0;
                  rsp_new_stream    <= !sts.hit && !sts.full;
                  rsp_table_full    <= !sts.hit && sts.full;
                  rsp_valid         <= 1'b1;
                  state_ff          <= RESP;
               end
            end
            RESP: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff  <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == RESP) else $error("rsp_valid outside resp");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result waits");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_new_stream && rsp_table_full)) else $error("new and full");

endmodule

>>> rtl/bidirectional_flow_id_assigner_core.sv
// bidirectional flow id assigner top level
// instantiates bfia_ctrl and bfia_datapath, uses bfia_pkg
//
// usage: one item enters on the req_ channel (req_valid/req_stall), its
// endpoints are ordered so both directions share one key, and the stored
// flows are scanned one entry per cycle from a flow memory with one read
// and one write port. one result leaves on the rsp_ channel
// (rsp_valid/rsp_stall) per item. a hit ends the scan early, and a packet
// without ip responds without waiting for the scan.
// only one item is in flight at a time; req_stall stays high until the
// result has been taken. the memory scan sets the rate.
// reset clears the flow count and the controller; memory contents need
// no clearing since only entries below the count are read.
// while rsp_stall is high the result holds and no new item is taken.
// table entries: FLOW_ENTRIES; stream numbers carry the low 8 index bits.
module bidirectional_flow_id_assigner_core #(
   parameter int FLOW_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_ip_present,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [63:0] req_dst_addr_hi,
   input  logic [63:0] req_dst_addr_lo,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_stream_valid,
   output logic [7:0]  rsp_stream_number,
   output logic        rsp_new_stream,
   output logic        rsp_table_full
);
   import bfia_pkg::*;

   localparam int IDX_W = $clog2(FLOW_ENTRIES);

   cmd_type    cmd;
   sts_type    sts;
   logic [7:0] number;

   bfia_datapath #(.FLOW_ENTRIES(FLOW_ENTRIES), .IDX_W(IDX_W)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_ip_present, .req_src_addr_hi, .req_src_addr_lo,
      .req_dst_addr_hi, .req_dst_addr_lo, .req_src_port, .req_dst_port,
      .number
   );

   bfia_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts, .number,
      .rsp_stream_valid, .rsp_stream_number, .rsp_new_stream, .rsp_table_full
   );

endmodule
